// File: rtl/core/prhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prhp_pkg
// Types and constants shared by the proxy request header parser.
// ----------------------------------------------------------------------------
package prhp_pkg;

   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_LF = 8'd10;

   // socks5 address type codes and fixed address lengths
   localparam logic [7:0] ATYP_IPV4   = 8'd1;
   localparam logic [7:0] ATYP_DOMAIN = 8'd3;
   localparam logic [7:0] ATYP_IPV6   = 8'd4;
   localparam logic [7:0] LEN_IPV4    = 8'd4;
   localparam logic [7:0] LEN_IPV6    = 8'd16;

   localparam logic [7:0] CONNECT_CODE_RESET = 8'd1;

   // field tags
   localparam logic [2:0] FK_PASSWORD  = 3'd0;
   localparam logic [2:0] FK_COMMAND   = 3'd1;
   localparam logic [2:0] FK_ADDR_TYPE = 3'd2;
   localparam logic [2:0] FK_ADDR_BYTE = 3'd3;
   localparam logic [2:0] FK_PORT_HIGH = 3'd4;
   localparam logic [2:0] FK_PORT_LOW  = 3'd5;
   localparam logic [2:0] FK_PAYLOAD   = 3'd6;
   localparam logic [2:0] FK_SEPARATOR = 3'd7;

   // address kinds as reported
   localparam logic [1:0] AK_NONE   = 2'd0;
   localparam logic [1:0] AK_IPV4   = 2'd1;
   localparam logic [1:0] AK_DOMAIN = 2'd2;
   localparam logic [1:0] AK_IPV6   = 2'd3;

   typedef enum logic [10:0] {
      PH_PASS = 11'b000_0000_0001,
      PH_CMD  = 11'b000_0000_0010,
      PH_ATYP = 11'b000_0000_0100,
      PH_DLEN = 11'b000_0000_1000,
      PH_ADDR = 11'b000_0001_0000,
      PH_PHI  = 11'b000_0010_0000,
      PH_PLO  = 11'b000_0100_0000,
      PH_CR2  = 11'b000_1000_0000,
      PH_LF2  = 11'b001_0000_0000,
      PH_PAY  = 11'b010_0000_0000,
      PH_DROP = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  field_kind;
      logic [1:0]  address_kind;
      logic [15:0] port_value;
      logic        message_end;
      logic        malformed;
   } result_type;

   // up to two result words per input byte
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } parse_out_type;

   function automatic result_type mk_result(input logic [7:0]  b,
                                            input logic [2:0]  kind,
                                            input logic [1:0]  ak,
                                            input logic [15:0] port);
      result_type r;
      r.out_byte     = b;
      r.field_kind   = kind;
      r.address_kind = ak;
      r.port_value   = port;
      r.message_end  = 1'b0;
      r.malformed    = 1'b0;
      return r;
   endfunction

endpackage

// File: rtl/core/prhp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prhp_parser
// Per-byte phase machine: tags one byte and updates the header state.
// ----------------------------------------------------------------------------
module prhp_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             byte_value,
   input  logic                   message_last,
   input  logic [7:0]             connect_code,
   output prhp_pkg::parse_out_type result
);

   prhp_pkg::phase_type phase_ff, phase_in;
   logic                held_cr_ff, held_cr_in;
   logic [1:0]          addr_kind_ff, addr_kind_in;
   logic [7:0]          bytes_left_ff, bytes_left_in;
   logic [7:0]          port_high_ff, port_high_in;
   logic                error_ff, error_in;

   always_comb begin
      prhp_pkg::result_type r0;
      prhp_pkg::result_type r1;
      logic [1:0]           n;
      logic                 bad;
      logic                 bad_status;

      phase_in      = phase_ff;
      held_cr_in    = held_cr_ff;
      addr_kind_in  = addr_kind_ff;
      bytes_left_in = bytes_left_ff;
      port_high_in  = port_high_ff;
      error_in      = error_ff;
      n             = 2'd0;
      bad           = 1'b0;
      r0            = '0;
      r1            = '0;

      unique case (phase_ff)
         prhp_pkg::PH_PASS: begin
            if (held_cr_ff) begin
               if (byte_value == prhp_pkg::CH_LF) begin
                  r0 = prhp_pkg::mk_result(prhp_pkg::CH_CR, prhp_pkg::FK_SEPARATOR,
                                           addr_kind_ff, 16'd0);
                  r1 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_SEPARATOR,
                                           addr_kind_ff, 16'd0);
                  n = 2'd2;
                  held_cr_in = 1'b0;
                  phase_in = prhp_pkg::PH_CMD;
               end else if (byte_value == prhp_pkg::CH_CR) begin
                  // release the older cr, keep the new one held
                  r0 = prhp_pkg::mk_result(prhp_pkg::CH_CR, prhp_pkg::FK_PASSWORD,
                                           addr_kind_ff, 16'd0);
                  n = 2'd1;
               end else begin
                  r0 = prhp_pkg::mk_result(prhp_pkg::CH_CR, prhp_pkg::FK_PASSWORD,
                                           addr_kind_ff, 16'd0);
                  r1 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_PASSWORD,
                                           addr_kind_ff, 16'd0);
                  n = 2'd2;
                  held_cr_in = 1'b0;
               end
            end else if (byte_value == prhp_pkg::CH_CR) begin
               held_cr_in = 1'b1;
            end else begin
               r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_PASSWORD,
                                        addr_kind_ff, 16'd0);
               n = 2'd1;
            end
            // a cr still held at message end goes out as password
            if (message_last && held_cr_in) begin
               if (n == 2'd0) begin
                  r0 = prhp_pkg::mk_result(prhp_pkg::CH_CR, prhp_pkg::FK_PASSWORD,
                                           addr_kind_ff, 16'd0);
               end else begin
                  r1 = prhp_pkg::mk_result(prhp_pkg::CH_CR, prhp_pkg::FK_PASSWORD,
                                           addr_kind_ff, 16'd0);
               end
               n = n + 2'd1;
               held_cr_in = 1'b0;
            end
         end
         prhp_pkg::PH_CMD: begin
            if (byte_value == connect_code) begin
               phase_in = prhp_pkg::PH_ATYP;
            end else begin
               bad = 1'b1;
            end
            r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_COMMAND, addr_kind_ff, 16'd0);
            n = 2'd1;
         end
         prhp_pkg::PH_ATYP: begin
            if (byte_value == prhp_pkg::ATYP_IPV4) begin
               addr_kind_in  = prhp_pkg::AK_IPV4;
               bytes_left_in = prhp_pkg::LEN_IPV4;
               phase_in      = prhp_pkg::PH_ADDR;
            end else if (byte_value == prhp_pkg::ATYP_DOMAIN) begin
               addr_kind_in = prhp_pkg::AK_DOMAIN;
               phase_in     = prhp_pkg::PH_DLEN;
            end else if (byte_value == prhp_pkg::ATYP_IPV6) begin
               addr_kind_in  = prhp_pkg::AK_IPV6;
               bytes_left_in = prhp_pkg::LEN_IPV6;
               phase_in      = prhp_pkg::PH_ADDR;
            end else begin
               bad = 1'b1;
            end
            r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_ADDR_TYPE, addr_kind_in, 16'd0);
            n = 2'd1;
         end
         prhp_pkg::PH_DLEN: begin
            r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_ADDR_BYTE, addr_kind_ff, 16'd0);
            n = 2'd1;
            bytes_left_in = byte_value;
            // empty domain skips straight to the port
            phase_in = (byte_value != 8'd0) ? prhp_pkg::PH_ADDR : prhp_pkg::PH_PHI;
         end
         prhp_pkg::PH_ADDR: begin
            r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_ADDR_BYTE, addr_kind_ff, 16'd0);
            n = 2'd1;
            if (bytes_left_ff <= 8'd1) begin
               bytes_left_in = 8'd0;
               phase_in = prhp_pkg::PH_PHI;
            end else begin
               bytes_left_in = bytes_left_ff - 8'd1;
            end
         end
         prhp_pkg::PH_PHI: begin
            port_high_in = byte_value;
            r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_PORT_HIGH, addr_kind_ff, 16'd0);
            n = 2'd1;
            phase_in = prhp_pkg::PH_PLO;
         end
         prhp_pkg::PH_PLO: begin
            r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_PORT_LOW, addr_kind_ff,
                                     {port_high_ff, byte_value});
            n = 2'd1;
            phase_in = prhp_pkg::PH_CR2;
         end
         prhp_pkg::PH_CR2: begin
            r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_SEPARATOR, addr_kind_ff, 16'd0);
            n = 2'd1;
            if (byte_value == prhp_pkg::CH_CR) begin
               phase_in = prhp_pkg::PH_LF2;
            end else begin
               bad = 1'b1;
            end
         end
         prhp_pkg::PH_LF2: begin
            r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_SEPARATOR, addr_kind_ff, 16'd0);
            n = 2'd1;
            if (byte_value == prhp_pkg::CH_LF) begin
               phase_in = prhp_pkg::PH_PAY;
            end else begin
               bad = 1'b1;
            end
         end
         prhp_pkg::PH_PAY: begin
            r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_PAYLOAD, addr_kind_ff, 16'd0);
            n = 2'd1;
         end
         default: begin
            // dropping: only a status word at message end
            if (message_last) begin
               r0 = prhp_pkg::mk_result(byte_value, prhp_pkg::FK_SEPARATOR,
                                        addr_kind_ff, 16'd0);
               n = 2'd1;
            end
         end
      endcase

      if (bad) begin
         error_in = 1'b1;
         phase_in = prhp_pkg::PH_DROP;
      end

      bad_status = error_in || (phase_in != prhp_pkg::PH_PAY);

      if (message_last) begin
         if (n == 2'd2) begin
            r1.message_end = 1'b1;
            r1.malformed   = bad_status;
         end else if (n == 2'd1) begin
            r0.message_end = 1'b1;
            r0.malformed   = bad_status;
         end
         phase_in      = prhp_pkg::PH_PASS;
         held_cr_in    = 1'b0;
         addr_kind_in  = prhp_pkg::AK_NONE;
         bytes_left_in = 8'd0;
         port_high_in  = 8'd0;
         error_in      = 1'b0;
      end

      result.count  = fire ? n : 2'd0;
      result.first  = r0;
      result.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= prhp_pkg::PH_PASS;
         held_cr_ff    <= 1'b0;
         addr_kind_ff  <= prhp_pkg::AK_NONE;
         bytes_left_ff <= 8'd0;
         port_high_ff  <= 8'd0;
         error_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         held_cr_ff    <= held_cr_in;
         addr_kind_ff  <= addr_kind_in;
         bytes_left_ff <= bytes_left_in;
         port_high_ff  <= port_high_in;
         error_ff      <= error_in;
      end
   end

endmodule

// File: rtl/core/prhp_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prhp_result_fifo
// Small result queue: takes up to two words a cycle, gives one a cycle.
// ----------------------------------------------------------------------------
module prhp_result_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  prhp_pkg::parse_out_type   push,
   input  logic                      pop,
   output prhp_pkg::result_type      head,
   output logic                      not_empty,
   output logic                      room_for_two,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   prhp_pkg::result_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] wr_next;

   function automatic logic [PtrW-1:0] step(input logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign wr_next = step(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1) begin
         wr_ptr_in = wr_next;
      end else if (push.count == 2'd2) begin
         wr_ptr_in = step(wr_next);
      end
      rd_ptr_in = pop ? step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push.count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= CntW'(DEPTH - 2));
   assign count        = count_ff;

endmodule

// File: rtl/core/proxy_request_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proxy_request_header_parser
// Tags each byte of a proxy request header and checks its layout.
// ----------------------------------------------------------------------------
// Request bytes enter on the req_ channel (req_valid / req_stall) one word at
// a time, req_message_last marking the final byte of a message. Tagged bytes
// leave on the rsp_ channel (rsp_valid / rsp_stall), one word per byte, two
// when a password CR is released together with the byte after it or with the
// LF of the separator, none for a CR that is being held or for a dropped byte
// other than the last of its message. An accepted byte is held in the input
// register, parsed straight out of it once the queue has room for two words,
// and its words are registered into the result queue, whose head is offered.
// One byte is taken every cycle while at least two queue places are free; the
// queue of RESULT_DEPTH words soaks up the extra word of a double result, and
// the input register stalls only when fewer than two queue places remain free,
// so that pace is set by the one-word-per-cycle output port.
// csr_wr_en writes the connect code (reset value 1); the user must use it only
// while the block is idle, which the block does not enforce. Reset empties
// the queue, clears the header state back to the password phase and restores
// the connect code. When the receiver stalls, the head word holds steady and,
// once the queue fills, req_stall rises; nothing is lost or reordered.
// ----------------------------------------------------------------------------
module proxy_request_header_parser #(
   parameter int RESULT_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_message_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_field_kind,
   output logic [1:0]  rsp_address_kind,
   output logic [15:0] rsp_port_value,
   output logic        rsp_message_end,
   output logic        rsp_malformed,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int CntW = $clog2(RESULT_DEPTH + 1);

   logic                    in_vld_ff;
   logic [7:0]              in_byte_ff;
   logic                    in_last_ff;
   logic [7:0]              connect_code_ff;
   logic                    fire;
   logic                    room_for_two;
   logic                    not_empty;
   logic [CntW-1:0]         q_count;
   prhp_pkg::parse_out_type parsed;
   prhp_pkg::result_type    head;

   assign fire      = in_vld_ff && room_for_two;
   assign req_stall = in_vld_ff && !room_for_two;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_message_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         connect_code_ff <= prhp_pkg::CONNECT_CODE_RESET;
      end else if (csr_wr_en) begin
         connect_code_ff <= csr_wr_data;
      end
   end

   prhp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .byte_value   (in_byte_ff),
      .message_last (in_last_ff),
      .connect_code (connect_code_ff),
      .result       (parsed)
   );

   prhp_result_fifo #(
      .DEPTH (RESULT_DEPTH)
   ) u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (parsed),
      .pop          (rsp_valid && !rsp_stall),
      .head         (head),
      .not_empty    (not_empty),
      .room_for_two (room_for_two),
      .count        (q_count)
   );

   assign rsp_valid        = not_empty;
   assign rsp_out_byte     = head.out_byte;
   assign rsp_field_kind   = head.field_kind;
   assign rsp_address_kind = head.address_kind;
   assign rsp_port_value   = head.port_value;
   assign rsp_message_end  = head.message_end;
   assign rsp_malformed    = head.malformed;

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CntW'(RESULT_DEPTH))
      else $error("result queue overfilled");

   // a parsed byte never meets a queue without two free places
   a_fire_room: assert property (@(posedge clock) disable iff (reset)
      (parsed.count != 2'd0) |-> room_for_two)
      else $error("parse without queue room");

   // status only on the last word of a message
   a_malformed_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_malformed) |-> rsp_message_end)
      else $error("malformed flag away from message end");

   // port value only on the port low word
   a_port_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_port_value != 16'd0) |-> (rsp_field_kind == prhp_pkg::FK_PORT_LOW))
      else $error("port value on wrong field");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the proxy request header parser.
// ----------------------------------------------------------------------------
// Request messages, a handful of hand-built ones and then random ones (mostly
// well-formed headers with random content, some truncated, broken or pure
// noise), are streamed in with bursty valid and a wandering rsp_stall. Every
// accepted byte is run through a local parser model that queues the tagged
// words it should produce; the monitor checks each output word against the
// oldest one. The connect code is rewritten between phases, only once the
// block has gone quiet.
// ----------------------------------------------------------------------------
module tb;
   import prhp_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_BYTES = 225;

   // receiver stall patterns
   localparam int STALL_NONE = 0;
   localparam int STALL_LIGHT = 1;
   localparam int STALL_HEAVY = 2;
   localparam int STALL_PERIODIC = 3;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } request_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = 8'd0;
   logic        req_message_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [2:0]  rsp_field_kind;
   logic [1:0]  rsp_address_kind;
   logic [15:0] rsp_port_value;
   logic        rsp_message_end;
   logic        rsp_malformed;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;

   proxy_request_header_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_value   (req_byte_value),
      .req_message_last (req_message_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_field_kind   (rsp_field_kind),
      .rsp_address_kind (rsp_address_kind),
      .rsp_port_value   (rsp_port_value),
      .rsp_message_end  (rsp_message_end),
      .rsp_malformed    (rsp_malformed),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   request_byte_type request_bytes[$];
   result_type       words_due[$];

   // parser model state
   logic [7:0] connect_code_q = CONNECT_CODE_RESET;
   phase_type  hdr_phase = PH_PASS;
   logic       cr_held = 1'b0;
   logic [1:0] addr_kind = AK_NONE;
   logic [7:0] addr_left = 8'd0;
   logic [7:0] port_hi = 8'd0;
   logic       hdr_error = 1'b0;

   int unsigned err_count = 0;
   int unsigned n_bytes = 0;
   int unsigned n_words = 0;
   int unsigned n_msgs = 0;
   int unsigned n_malformed = 0;

   function automatic result_type make_word(input logic [7:0] b, input logic [2:0] kind,
                                            input logic [15:0] port);
      result_type w;
      w.out_byte     = b;
      w.field_kind   = kind;
      w.address_kind = addr_kind;
      w.port_value   = port;
      w.message_end  = 1'b0;
      w.malformed    = 1'b0;
      return w;
   endfunction

   // works out the words one accepted byte gives and queues them
   function automatic void parse_byte(input logic [7:0] b, input logic last);
      result_type words[$];
      logic       bad;
      int         k;
      bad = 1'b0;
      case (hdr_phase)
         PH_PASS: begin
            if (cr_held) begin
               if (b == CH_LF) begin
                  words.push_back(make_word(CH_CR, FK_SEPARATOR, 16'd0));
                  words.push_back(make_word(b, FK_SEPARATOR, 16'd0));
                  cr_held = 1'b0;
                  hdr_phase = PH_CMD;
               end else if (b == CH_CR) begin
                  words.push_back(make_word(CH_CR, FK_PASSWORD, 16'd0));
               end else begin
                  words.push_back(make_word(CH_CR, FK_PASSWORD, 16'd0));
                  words.push_back(make_word(b, FK_PASSWORD, 16'd0));
                  cr_held = 1'b0;
               end
            end else if (b == CH_CR) begin
               cr_held = 1'b1;
            end else begin
               words.push_back(make_word(b, FK_PASSWORD, 16'd0));
            end
            // a cr still held at message end goes out as password
            if (last && cr_held) begin
               words.push_back(make_word(CH_CR, FK_PASSWORD, 16'd0));
               cr_held = 1'b0;
            end
         end
         PH_CMD: begin
            if (b == connect_code_q) hdr_phase = PH_ATYP;
            else bad = 1'b1;
            words.push_back(make_word(b, FK_COMMAND, 16'd0));
         end
         PH_ATYP: begin
            if (b == ATYP_IPV4) begin
               addr_kind = AK_IPV4;
               addr_left = LEN_IPV4;
               hdr_phase = PH_ADDR;
            end else if (b == ATYP_DOMAIN) begin
               addr_kind = AK_DOMAIN;
               hdr_phase = PH_DLEN;
            end else if (b == ATYP_IPV6) begin
               addr_kind = AK_IPV6;
               addr_left = LEN_IPV6;
               hdr_phase = PH_ADDR;
            end else begin
               bad = 1'b1;
            end
            words.push_back(make_word(b, FK_ADDR_TYPE, 16'd0));
         end
         PH_DLEN: begin
            words.push_back(make_word(b, FK_ADDR_BYTE, 16'd0));
            addr_left = b;
            hdr_phase = (b != 8'd0) ? PH_ADDR : PH_PHI;
         end
         PH_ADDR: begin
            words.push_back(make_word(b, FK_ADDR_BYTE, 16'd0));
            if (addr_left <= 8'd1) begin
               addr_left = 8'd0;
               hdr_phase = PH_PHI;
            end else begin
               addr_left = addr_left - 8'd1;
            end
         end
         PH_PHI: begin
            port_hi = b;
            words.push_back(make_word(b, FK_PORT_HIGH, 16'd0));
            hdr_phase = PH_PLO;
         end
         PH_PLO: begin
            words.push_back(make_word(b, FK_PORT_LOW, {port_hi, b}));
            hdr_phase = PH_CR2;
         end
         PH_CR2: begin
            words.push_back(make_word(b, FK_SEPARATOR, 16'd0));
            if (b == CH_CR) hdr_phase = PH_LF2;
            else bad = 1'b1;
         end
         PH_LF2: begin
            words.push_back(make_word(b, FK_SEPARATOR, 16'd0));
            if (b == CH_LF) hdr_phase = PH_PAY;
            else bad = 1'b1;
         end
         PH_PAY: begin
            words.push_back(make_word(b, FK_PAYLOAD, 16'd0));
         end
         default: begin
            // dropping: only the last byte gives a status word
            if (last) words.push_back(make_word(b, FK_SEPARATOR, 16'd0));
         end
      endcase
      if (bad) begin
         hdr_error = 1'b1;
         hdr_phase = PH_DROP;
      end
      if (last) begin
         if (words.size() > 0) begin
            k = words.size() - 1;
            words[k].message_end = 1'b1;
            words[k].malformed = hdr_error || (hdr_phase != PH_PAY);
            if (words[k].malformed) n_malformed++;
         end
         n_msgs++;
         hdr_phase = PH_PASS;
         cr_held = 1'b0;
         addr_kind = AK_NONE;
         addr_left = 8'd0;
         port_hi = 8'd0;
         hdr_error = 1'b0;
      end
      foreach (words[i]) words_due.push_back(words[i]);
   endfunction

   function automatic void queue_bytes(input logic [7:0] msg[$]);
      request_byte_type item;
      foreach (msg[i]) begin
         item.value = msg[i];
         item.last = (i == msg.size() - 1);
         request_bytes.push_back(item);
      end
   endfunction

   // one random message; mostly a sound header with random content
   function automatic int unsigned queue_message();
      logic [7:0]  msg[$];
      logic [7:0]  atyp;
      int unsigned alen;
      int unsigned cut;
      int unsigned pick;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 24)) msg.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 12)) begin
            if ($urandom_range(0, 7) == 0) msg.push_back(CH_CR);
            else msg.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 19) != 0) begin
            msg.push_back(CH_CR);
            msg.push_back(CH_LF);
         end
         if ($urandom_range(0, 9) == 0) msg.push_back(8'($urandom_range(0, 255)));
         else msg.push_back(connect_code_q);
         pick = $urandom_range(0, 9);
         if (pick < 3) atyp = ATYP_IPV4;
         else if (pick < 6) atyp = ATYP_DOMAIN;
         else if (pick < 9) atyp = ATYP_IPV6;
         else atyp = 8'($urandom_range(0, 255));
         msg.push_back(atyp);
         if (atyp == ATYP_IPV4) begin
            alen = LEN_IPV4;
         end else if (atyp == ATYP_IPV6) begin
            alen = LEN_IPV6;
         end else if (atyp == ATYP_DOMAIN) begin
            // long names only now and then
            alen = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 20);
            msg.push_back(8'(alen));
         end else begin
            alen = $urandom_range(0, 4);
         end
         repeat (alen + 2) msg.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) != 0) begin
            msg.push_back(CH_CR);
            msg.push_back(CH_LF);
         end else begin
            msg.push_back($urandom_range(0, 1) ? CH_CR : 8'($urandom_range(0, 255)));
            msg.push_back($urandom_range(0, 1) ? CH_LF : 8'($urandom_range(0, 255)));
         end
         repeat ($urandom_range(0, 10)) msg.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 6) == 0 && msg.size() > 1) begin
         cut = $urandom_range(1, msg.size() - 1);
         while (msg.size() > cut) void'(msg.pop_back());
      end
      queue_bytes(msg);
      return msg.size();
   endfunction

   // driver: bursts of random length with random gaps
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      request_byte_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_byte_value, req_message_last);
            n_bytes++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0 || request_bytes.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               item = request_bytes.pop_front();
               req_valid <= 1'b1;
               req_byte_value <= item.value;
               req_message_last <= item.last;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // receiver stall pattern, switching between styles
   int unsigned stall_mode = STALL_NONE;
   int unsigned mode_left = 0;
   int unsigned stall_tick = 0;

   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(STALL_NONE, STALL_PERIODIC);
         mode_left <= $urandom_range(20, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 85);
         default: rsp_stall <= (stall_tick % 5 == 0);
      endcase
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (err_count < 40)
         $display("mismatch at word %0d: %s got %0h want %0h", n_words, what, got, want);
      err_count++;
   endtask

   // monitor: each accepted word against the oldest one due
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (words_due.size() == 0) begin
            report_mismatch("unexpected word, byte", rsp_out_byte, 0);
         end else begin
            want = words_due.pop_front();
            if (rsp_out_byte != want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_field_kind != want.field_kind)
               report_mismatch("field_kind", rsp_field_kind, want.field_kind);
            if (rsp_address_kind != want.address_kind)
               report_mismatch("address_kind", rsp_address_kind, want.address_kind);
            if (rsp_port_value != want.port_value)
               report_mismatch("port_value", rsp_port_value, want.port_value);
            if (rsp_message_end != want.message_end)
               report_mismatch("message_end", rsp_message_end, want.message_end);
            if (rsp_malformed != want.malformed)
               report_mismatch("malformed", rsp_malformed, want.malformed);
         end
         n_words++;
      end
   end

   // watchdog on cycles with no word moving on either side
   int unsigned stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles", STUCK_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic wait_idle();
      @(negedge clock);
      while (request_bytes.size() != 0 || req_valid || words_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_connect_code(input logic [7:0] code);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      connect_code_q = code;
      @(negedge clock);
   endtask

   initial begin
      logic [7:0]  codes[6];
      int unsigned added;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // hand-built messages under the reset connect code
      queue_bytes('{CH_CR});
      queue_bytes('{CH_CR, 8'h78});
      queue_bytes('{CH_CR, CH_CR, CH_LF, CONNECT_CODE_RESET, ATYP_DOMAIN, 8'h00,
                    8'h00, 8'h00, CH_CR, CH_LF});
      queue_bytes('{CH_CR, CH_LF, 8'hFF, 8'h00});
      queue_bytes('{CH_CR, CH_LF, CONNECT_CODE_RESET, ATYP_DOMAIN, 8'h00, 8'hFF, 8'hFF,
                    CH_CR, 8'h5A});
      wait_idle();

      codes[0] = 8'h00;
      codes[1] = 8'hFF;
      codes[2] = 8'($urandom_range(0, 255));
      codes[3] = CONNECT_CODE_RESET;
      codes[4] = 8'($urandom_range(0, 255));
      codes[5] = 8'($urandom_range(0, 255));
      foreach (codes[p]) begin
         write_connect_code(codes[p]);
         added = 0;
         while (added < PHASE_BYTES) added += queue_message();
         wait_idle();
      end

      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      $display("covered %0d request bytes in %0d messages (%0d malformed), %0d words checked",
               n_bytes, n_msgs, n_malformed, n_words);
      $display("connect code swept through 00, ff, the reset value and random codes");
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", err_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule
